[design/bcrc24_pkg.sv]
// Package for the BLE CRC-24 forward/reverse engine: constants, item type
// and the per-byte LFSR functions. No dependencies.
`timescale 1ns / 1ps

package bcrc24_pkg;

    localparam int CRC_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 3;
    localparam int OUT_W   = 24;

    localparam logic [CRC_W-1:0] FWD_TAPS = 24'h5a6000;
    localparam logic [CRC_W-1:0] REV_TAPS = 24'hb4c000;
    localparam logic [CRC_W-1:0] CRC_MASK = 24'hffffff;

    // mode codes
    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_REV = 1'b1;

    // one input word, unpacked
    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              first;
        logic              last;
        logic [CRC_W-1:0]  seed;
    } item_t;

    // reflected lfsr, lsb of the byte first
    function automatic logic [CRC_W-1:0] fwd_byte(input logic [CRC_W-1:0] s_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] s;
        logic             fb;
        s = s_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb = s[0] ^ b[k];
            s  = {1'b0, s[CRC_W-1:1]};
            if (fb)
            begin
                s = (s | {1'b1, {(CRC_W-1){1'b0}}}) ^ FWD_TAPS;
            end
        end
        return s & CRC_MASK;
    endfunction

    // lfsr run backwards, msb of the byte first
    function automatic logic [CRC_W-1:0] rev_byte(input logic [CRC_W-1:0] s_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] s;
        logic             top;
        s = s_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            top = s[CRC_W-1];
            s   = {s[CRC_W-2:0], top ^ b[BYTE_W-1-k]};
            if (top)
            begin
                s = s ^ REV_TAPS;
            end
        end
        return s;
    endfunction

    // bit order reversal of the 24-bit state
    function automatic logic [CRC_W-1:0] reverse24(input logic [CRC_W-1:0] s);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++)
        begin
            r[CRC_W-1-k] = s[k];
        end
        return r;
    endfunction

endpackage

[design/ble_crc24_forward_reverse_top.sv]
// BLE CRC-24 forward/reverse engine, top level.
// Depends on bcrc24_pkg and bcrc24_step.
//
// Use: bytes of a message arrive one word per cycle on the s_axis channel
// while no final word is held back. tuser carries func, byte_valid and
// first; tlast marks the end of the message. On the first word the seed
// (tdata[31:8]) and mode are loaded: forward mode gives the CRC of the
// bytes, reverse mode is fed the bytes last first starting from a received
// CRC and gives the recovered CRCInit. A word with byte_valid low only
// loads/ends, so an empty message is one word with first and last set.
// One result word leaves on m_axis for each word with tlast set; other
// words give none.
// A word is captured in the input register; its byte then goes through
// the combinational eight-bit LFSR update into the state register, and
// a final word's result into the result register.
// Throughput: one word per cycle, as long as no final word is held back
// by a waiting result.
// Reset clears the LFSR state to zero, the mode to forward and both valid
// flags. When the receiver stalls with a result waiting, non-final words
// keep flowing; a final word holds in the input register, with
// s_axis_tready low, until the result register frees.
`timescale 1ns / 1ps

module ble_crc24_forward_reverse_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte [7:0], seed [31:8]
    input  logic [bcrc24_pkg::TDATA_W-1:0]    s_axis_tdata,
    // func [0], byte_valid [1], first [2]
    input  logic [bcrc24_pkg::TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // crc_value [23:0]
    output logic [bcrc24_pkg::OUT_W-1:0]      m_axis_tdata
);
    import bcrc24_pkg::*;

    item_t            in_item_reg;
    logic             in_valid_reg;
    logic [CRC_W-1:0] lfsr_state_reg;
    logic             mode_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_valid_reg;

    logic             in_valid_next;
    logic             out_valid_next;
    logic             advance;
    logic             out_free;
    logic             s_accept;
    logic [CRC_W-1:0] state_next;
    logic             mode_next;
    logic [OUT_W-1:0] crc_value;
    item_t            s_item;

    // unpack the incoming word
    always_comb
    begin
        s_item.func       = s_axis_tuser[0];
        s_item.byte_valid = s_axis_tuser[1];
        s_item.first      = s_axis_tuser[2];
        s_item.data_byte  = s_axis_tdata[BYTE_W-1:0];
        s_item.seed       = s_axis_tdata[BYTE_W+CRC_W-1:BYTE_W];
        s_item.last       = s_axis_tlast;
    end

    // handshake: a word moves on unless it is final and the result slot is full
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (out_free || !in_item_reg.last);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = (advance && in_item_reg.last) ? 1'b1
                          : (m_axis_tready ? 1'b0 : out_valid_reg);

    bcrc24_step u_step (
        .item       (in_item_reg),
        .state      (lfsr_state_reg),
        .mode       (mode_reg),
        .state_next (state_next),
        .mode_next  (mode_next),
        .crc_value  (crc_value)
    );

    // control and lfsr state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lfsr_state_reg <= '0;
            mode_reg       <= MODE_FWD;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                lfsr_state_reg <= state_next;
                mode_reg       <= mode_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (advance && in_item_reg.last)
        begin
            out_data_reg <= crc_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // an empty input register never blocks the upstream side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but not ready");

    // a final word that moves on always yields a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.last) |=> m_axis_tvalid)
        else $error("final word produced no result");

    // a word without byte or seed leaves the lfsr untouched
    a_no_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_item_reg.byte_valid && !in_item_reg.first)
        |=> lfsr_state_reg == $past(lfsr_state_reg))
        else $error("lfsr changed on a word without byte");

    // the mode follows func on a first word
    a_mode_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.first) |=> mode_reg == $past(in_item_reg.func))
        else $error("mode not loaded on first word");

endmodule

[design/bcrc24_step.sv]
// Combinational byte step of the CRC-24 engine: seed load, one byte of
// forward or reverse LFSR, and the result word. Uses bcrc24_pkg.
`timescale 1ns / 1ps

module bcrc24_step (
    input  bcrc24_pkg::item_t             item,
    input  logic [bcrc24_pkg::CRC_W-1:0]  state,
    input  logic                          mode,
    output logic [bcrc24_pkg::CRC_W-1:0]  state_next,
    output logic                          mode_next,
    output logic [bcrc24_pkg::OUT_W-1:0]  crc_value
);
    import bcrc24_pkg::*;

    logic [CRC_W-1:0] base;

    // seed and mode are taken on the first word of a message
    always_comb
    begin
        base      = item.first ? item.seed : state;
        mode_next = item.first ? item.func : mode;
    end

    // one byte through the selected lfsr
    always_comb
    begin
        state_next = base;
        if (item.byte_valid)
        begin
            if (mode_next == MODE_REV)
            begin
                state_next = rev_byte(base, item.data_byte);
            end
            else
            begin
                state_next = fwd_byte(base, item.data_byte);
            end
        end
    end

    // reverse mode hands back the bit-reversed state
    assign crc_value = (mode_next == MODE_REV) ? reverse24(state_next) : state_next;

endmodule

[tb/sv/ble_crc24_forward_reverse_monitor.sv]
// Stream monitor for the BLE CRC-24 forward/reverse engine: follows both
// channels, predicts every result word and compares it with the block's output.
// Depends on bcrc24_pkg for widths, tap masks and mode codes.
`timescale 1ns / 1ps

module ble_crc24_forward_reverse_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // data_byte [7:0], seed [31:8]
    input  logic [bcrc24_pkg::TDATA_W-1:0]   s_tdata,
    // func [0], byte_valid [1], first [2]
    input  logic [bcrc24_pkg::TUSER_W-1:0]   s_tuser,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // crc_value [23:0]
    input  logic [bcrc24_pkg::OUT_W-1:0]     m_tdata,
    output int unsigned                      failures,
    output int unsigned                      outstanding
);
    import bcrc24_pkg::*;

    // tuser field positions
    localparam int U_FUNC  = 0;
    localparam int U_VALID = 1;
    localparam int U_FIRST = 2;

    logic [CRC_W-1:0] crc_state;
    logic             crc_mode;
    logic [OUT_W-1:0] crc_expected_q[$];
    logic [OUT_W-1:0] crc_wanted;
    int unsigned      fail_tally;

    // one byte through the reflected lfsr, lsb first
    function automatic logic [CRC_W-1:0] next_fwd_state(input logic [CRC_W-1:0] st,
                                                        input logic [BYTE_W-1:0] b);
        logic fb;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb = st[0] ^ b[i];
            st = {fb, st[CRC_W-1:1]} ^ (fb ? FWD_TAPS : '0);
        end
        return st;
    endfunction

    // one byte through the lfsr run backwards, msb first
    function automatic logic [CRC_W-1:0] next_rev_state(input logic [CRC_W-1:0] st,
                                                        input logic [BYTE_W-1:0] b);
        logic msb;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            msb = st[CRC_W-1];
            st  = {st[CRC_W-2:0], msb ^ b[i]} ^ (msb ? REV_TAPS : '0);
        end
        return st;
    endfunction

    function automatic logic [CRC_W-1:0] mirror24(input logic [CRC_W-1:0] st);
        logic [CRC_W-1:0] m;
        for (int i = 0; i < CRC_W; i++)
        begin
            m[i] = st[CRC_W-1-i];
        end
        return m;
    endfunction

    // prediction on accepted input words, comparison on accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_state = '0;
            crc_mode  = MODE_FWD;
            crc_expected_q.delete();
            fail_tally = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[U_FIRST])
                begin
                    crc_state = s_tdata[TDATA_W-1:BYTE_W];
                    crc_mode  = s_tuser[U_FUNC];
                end
                if (s_tuser[U_VALID])
                begin
                    crc_state = (crc_mode == MODE_REV)
                              ? next_rev_state(crc_state, s_tdata[BYTE_W-1:0])
                              : next_fwd_state(crc_state, s_tdata[BYTE_W-1:0]);
                end
                if (s_tlast)
                begin
                    crc_expected_q.push_back((crc_mode == MODE_REV) ? mirror24(crc_state)
                                                                    : crc_state);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (crc_expected_q.size() == 0)
                begin
                    $error("unexpected result word, crc_value %06h", m_tdata);
                    fail_tally++;
                end
                else
                begin
                    crc_wanted = crc_expected_q.pop_front();
                    if (crc_wanted !== m_tdata)
                    begin
                        $error("crc_value mismatch: expected %06h, actual %06h",
                               crc_wanted, m_tdata);
                        fail_tally++;
                    end
                end
            end
            failures    <= fail_tally;
            outstanding <= crc_expected_q.size();
        end
    end

endmodule

[tb/sv/ble_crc24_forward_reverse_top_test.sv]
// Testbench top for the BLE CRC-24 forward/reverse engine: clock, reset,
// message stimulus with random idling on both channels, and the verdict.
// Depends on bcrc24_pkg, the engine top and ble_crc24_forward_reverse_monitor.
`timescale 1ns / 1ps

module ble_crc24_forward_reverse_top_test;

    import bcrc24_pkg::*;

    localparam int WORD_TARGET = 1850;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic [TUSER_W-1:0]  s_axis_tuser = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned words_sent = 0;
    bit          tx_eager = 1'b0;
    bit          rx_eager = 1'b0;
    bit          hold_req = 1'b0;

    ble_crc24_forward_reverse_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ble_crc24_forward_reverse_monitor crc_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .s_tlast     (s_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // offer one word after a random gap and wait until it is taken
    task automatic send_word(input logic fn, input logic [BYTE_W-1:0] b, input logic bv,
                             input logic fst, input logic lst, input logic [CRC_W-1:0] sd);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sd, b};
        s_axis_tuser  <= {fst, bv, fn};
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // message of random bytes; first and last may be left off for broken runs
    task automatic send_message(input logic fn, input logic [CRC_W-1:0] sd, input int len,
                                input bit with_first, input bit with_last);
        logic bv;
        for (int i = 0; i < len; i++)
        begin
            bv = ($urandom_range(0, 9) != 0);
            send_word((i == 0) ? fn : 1'($urandom_range(0, 1)),
                      BYTE_W'($urandom_range(0, 255)), bv,
                      with_first && (i == 0), with_last && (i == len - 1),
                      (i == 0) ? sd : CRC_W'($urandom_range(0, 24'hffffff)));
        end
    endtask

    // stop offering until every predicted result has left the block
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // receiver: random stall per result word, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_eager = !rx_eager;
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_eager ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // stimulus and verdict
    initial
    begin
        bit          fill_done;
        bit          pause_done;
        bit          saved_eager;
        int unsigned pick;
        int          len;
        logic [CRC_W-1:0] sd;

        fill_done  = 1'b0;
        pause_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no first word after reset continues from state zero, forward
        send_word(MODE_REV, 8'ha5, 1'b1, 1'b0, 1'b1, 24'hffffff);
        // empty messages in both modes
        send_word(MODE_FWD, 8'h00, 1'b0, 1'b1, 1'b1, 24'hffffff);
        send_word(MODE_REV, 8'hff, 1'b0, 1'b1, 1'b1, 24'h000001);
        send_word(MODE_REV, 8'h00, 1'b0, 1'b1, 1'b1, 24'h800000);
        // single bytes at the extremes
        send_word(MODE_FWD, 8'hff, 1'b1, 1'b1, 1'b1, 24'h555555);
        send_word(MODE_FWD, 8'h00, 1'b1, 1'b1, 1'b1, 24'h000000);
        send_word(MODE_REV, 8'h00, 1'b1, 1'b1, 1'b1, 24'hffffff);
        send_word(MODE_REV, 8'hff, 1'b1, 1'b1, 1'b1, 24'h000000);
        // forward message with a byteless word whose func must be ignored
        send_word(MODE_FWD, 8'h00, 1'b1, 1'b1, 1'b0, 24'h000000);
        send_word(MODE_REV, 8'h3c, 1'b0, 1'b0, 1'b0, 24'hffffff);
        send_word(MODE_REV, 8'h80, 1'b1, 1'b0, 1'b1, 24'h123456);
        // state kept after the end, next word carries on
        send_word(MODE_REV, 8'h01, 1'b1, 1'b0, 1'b1, 24'h000000);
        // reverse message, then carry on in reverse without a first word
        send_word(MODE_REV, 8'h12, 1'b1, 1'b1, 1'b0, 24'habcdef);
        send_word(MODE_FWD, 8'h34, 1'b1, 1'b0, 1'b0, 24'h000000);
        send_word(MODE_FWD, 8'h56, 1'b1, 1'b0, 1'b1, 24'h000000);
        send_word(MODE_FWD, 8'h78, 1'b1, 1'b0, 1'b1, 24'hffffff);
        // end of message on a byteless word
        send_word(MODE_FWD, 8'h9a, 1'b1, 1'b1, 1'b0, 24'h0f0f0f);
        send_word(MODE_REV, 8'hbc, 1'b0, 1'b0, 1'b1, 24'hf0f0f0);
        // reload mid-message without an end in between
        send_word(MODE_REV, 8'hde, 1'b1, 1'b1, 1'b0, 24'haaaaaa);
        send_word(MODE_FWD, 8'hf0, 1'b1, 1'b1, 1'b1, 24'h555555);
        drain_results();

        // random messages
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                tx_eager = !tx_eager;

            // long receiver hold-off while short messages keep arriving
            if (!fill_done && words_sent >= 600)
            begin
                fill_done   = 1'b1;
                saved_eager = tx_eager;
                tx_eager    = 1'b1;
                hold_req    = 1'b1;
                for (int i = 0; i < 12; i++)
                    send_message(1'($urandom_range(0, 1)),
                                 CRC_W'($urandom_range(0, 24'hffffff)),
                                 $urandom_range(1, 2), 1'b1, 1'b1);
                tx_eager = saved_eager;
            end
            if (!pause_done && words_sent >= 1200)
            begin
                pause_done = 1'b1;
                drain_results();
            end

            pick = $urandom_range(0, 15);
            case ($urandom_range(0, 7))
                0:       sd = 24'h000000;
                1:       sd = 24'hffffff;
                default: sd = CRC_W'($urandom_range(0, 24'hffffff));
            endcase
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                               : $urandom_range(1, 6);
            if (pick == 0)
                send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), CRC_W'($urandom_range(0, 24'hffffff)));
            else if (pick == 1)
                send_message(1'($urandom_range(0, 1)), sd, len, 1'b0, 1'b1);
            else if (pick == 2)
                send_message(1'($urandom_range(0, 1)), sd, len, 1'b1, 1'b0);
            else
                send_message(1'($urandom_range(0, 1)), sd, len, 1'b1, 1'b1);
        end

        drain_results();
        if (failures == 0)
            $display("[ble_crc24_forward_reverse_top] OK");
        else
            $display("[ble_crc24_forward_reverse_top] ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #4_000_000;
        $display("[ble_crc24_forward_reverse_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
design/bcrc24_pkg.sv
design/bcrc24_step.sv
design/ble_crc24_forward_reverse_top.sv
tb/sv/ble_crc24_forward_reverse_monitor.sv
tb/sv/ble_crc24_forward_reverse_top_test.sv
